FILE: rtl/vtlcd_pkg.sv
`timescale 1ns / 1ps

package vtlcd_pkg;

  // Register file of the configuration port.
  localparam int unsigned CfgCount = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned AddrW    = 7;

  localparam int unsigned RowCountDefault = 4;

  typedef logic [AddrW-1:0] addr_t;

  localparam addr_t RowBaseReset [CfgCount] = '{7'd0, 7'd64, 7'd20, 7'd84};

  // Sequence positions. Position n means n characters of the sequence are behind us.
  localparam int unsigned SeqChars = 5;
  localparam int unsigned PosW     = 3;

  localparam logic [PosW-1:0] SeqIdle  = 3'd0;
  localparam logic [PosW-1:0] SeqEsc   = 3'd1;
  localparam logic [PosW-1:0] SeqPos2  = 3'd2;
  localparam logic [PosW-1:0] SeqPos3  = 3'd3;
  localparam logic [PosW-1:0] SeqPos4  = 3'd4;
  localparam logic [PosW-1:0] SeqPos5  = 3'd5;
  localparam logic [PosW-1:0] SeqPos6  = 3'd6;
  localparam logic [PosW-1:0] SeqPos7  = 3'd7;

  // Characters the parser looks for.
  localparam logic [7:0] ChEsc     = 8'h1b;
  localparam logic [7:0] ChBracket = 8'h5b;
  localparam logic [7:0] ChQuest   = 8'h3f;
  localparam logic [7:0] ChSemi    = 8'h3b;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChTwo     = 8'h32;
  localparam logic [7:0] ChFive    = 8'h35;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperJ  = 8'h4a;
  localparam logic [7:0] ChUpperH  = 8'h48;
  localparam logic [7:0] ChLowerH  = 8'h68;
  localparam logic [7:0] ChLowerL  = 8'h6c;

  // Controller commands.
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdDispOn      = 8'h0c;
  localparam logic [7:0] CmdDispCursor  = 8'h0e;
  // The set-address command carries the display address in its low seven bits.
  localparam logic [7:0] CmdDdram       = 8'h80;

  localparam logic RsCommand = 1'b0;
  localparam logic RsData    = 1'b1;

  // Parser state: position, digit flags of positions 2..6, stored characters 2..6.
  typedef struct packed {
    logic [PosW-1:0]              pos;
    logic [SeqChars-1:0]          dig;
    logic [SeqChars-1:0][7:0]     chr;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic       reg_select;
    logic [7:0] bus_byte;
  } parse_result_t;

endpackage

FILE: rtl/vtlcd_step.sv
`timescale 1ns / 1ps

// One parser step: current character plus stored state in, next state and result out.
module vtlcd_step #(
  parameter int unsigned ROW_COUNT = vtlcd_pkg::RowCountDefault,
  localparam int unsigned RowIdxW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
  input  logic [7:0]              char_i,
  input  vtlcd_pkg::parse_state_t st_i,
  input  vtlcd_pkg::addr_t        row_base_i [ROW_COUNT],
  output vtlcd_pkg::parse_state_t st_o,
  output vtlcd_pkg::parse_result_t res_o
);

  function automatic logic [6:0] times10(input logic [3:0] a);
    times10 = {a, 3'b000} + {2'b00, a, 1'b0};
  endfunction

  logic                      is_dig;
  logic                      keep;
  logic                      go;
  logic [6:0]                col;
  logic [6:0]                row;
  logic [1:0]                row_sat;
  logic [7:0]                s2, s3, s4;
  logic [3:0]                n2, n3, n4, n5, n6;
  logic                      f2, f3, f4, f5, f6;
  logic [2:0]                wr_idx;
  vtlcd_pkg::addr_t          addr;

  assign is_dig = (char_i >= vtlcd_pkg::ChZero) && (char_i <= vtlcd_pkg::ChNine);

  assign s2 = st_i.chr[0];
  assign s3 = st_i.chr[1];
  assign s4 = st_i.chr[2];
  // Digits carry their value in the low nibble.
  assign n2 = st_i.chr[0][3:0];
  assign n3 = st_i.chr[1][3:0];
  assign n4 = st_i.chr[2][3:0];
  assign n5 = st_i.chr[3][3:0];
  assign n6 = st_i.chr[4][3:0];
  assign f2 = st_i.dig[0];
  assign f3 = st_i.dig[1];
  assign f4 = st_i.dig[2];
  assign f5 = st_i.dig[3];
  assign f6 = st_i.dig[4];
  assign wr_idx = 3'(st_i.pos - vtlcd_pkg::SeqPos2);

  always_comb begin
    st_o  = st_i;
    keep  = 1'b0;
    go    = 1'b0;
    col   = '0;
    row   = '0;
    res_o = '{emit: 1'b0, reg_select: vtlcd_pkg::RsCommand, bus_byte: 8'h00};

    if (st_i.pos >= vtlcd_pkg::SeqPos2 && st_i.pos <= vtlcd_pkg::SeqPos6) begin
      st_o.chr[wr_idx] = char_i;
      if (is_dig) begin
        st_o.dig[wr_idx] = 1'b1;
      end
    end

    unique case (st_i.pos)
      vtlcd_pkg::SeqIdle: begin
        if (char_i != vtlcd_pkg::ChEsc) begin
          res_o = '{emit: 1'b1, reg_select: vtlcd_pkg::RsData, bus_byte: char_i};
        end else begin
          keep = 1'b1;
        end
      end
      vtlcd_pkg::SeqEsc: begin
        st_o.dig = '0;
        keep     = (char_i == vtlcd_pkg::ChBracket);
      end
      vtlcd_pkg::SeqPos2: begin
        keep = (char_i == vtlcd_pkg::ChQuest) || is_dig;
      end
      vtlcd_pkg::SeqPos3: begin
        if (s2 == vtlcd_pkg::ChQuest) begin
          keep = (char_i == vtlcd_pkg::ChTwo);
        end else if (s2 == vtlcd_pkg::ChTwo && char_i == vtlcd_pkg::ChUpperJ) begin
          res_o.emit     = 1'b1;
          res_o.bus_byte = vtlcd_pkg::CmdClear;
        end else begin
          keep = f2 && ((char_i == vtlcd_pkg::ChSemi) || is_dig);
        end
      end
      vtlcd_pkg::SeqPos4: begin
        if (s2 == vtlcd_pkg::ChQuest) begin
          keep = (s3 == vtlcd_pkg::ChTwo) && (char_i == vtlcd_pkg::ChFive);
        end else if (f2) begin
          keep = ((s3 == vtlcd_pkg::ChSemi) && is_dig) ||
                 (f3 && (char_i == vtlcd_pkg::ChSemi));
        end
      end
      vtlcd_pkg::SeqPos5: begin
        if (s2 == vtlcd_pkg::ChQuest) begin
          if (s3 == vtlcd_pkg::ChTwo && s4 == vtlcd_pkg::ChFive) begin
            if (char_i == vtlcd_pkg::ChLowerH) begin
              res_o.emit     = 1'b1;
              res_o.bus_byte = vtlcd_pkg::CmdDispCursor;
            end else if (char_i == vtlcd_pkg::ChLowerL) begin
              res_o.emit     = 1'b1;
              res_o.bus_byte = vtlcd_pkg::CmdDispOn;
            end
          end
        end else if (f2) begin
          if (s3 == vtlcd_pkg::ChSemi && f4) begin
            if (char_i == vtlcd_pkg::ChUpperH) begin
              go  = 1'b1;
              col = {3'b000, n4};
              row = {3'b000, n2};
            end else begin
              keep = is_dig;
            end
          end else begin
            keep = f3 && (s4 == vtlcd_pkg::ChSemi) && is_dig;
          end
        end
      end
      vtlcd_pkg::SeqPos6: begin
        if (f2) begin
          if (s3 == vtlcd_pkg::ChSemi && f4 && f5 && char_i == vtlcd_pkg::ChUpperH) begin
            go  = 1'b1;
            col = times10(n4) + {3'b000, n5};
            row = {3'b000, n2};
          end else if (f3 && s4 == vtlcd_pkg::ChSemi && f5) begin
            if (char_i == vtlcd_pkg::ChUpperH) begin
              go  = 1'b1;
              col = {3'b000, n5};
              row = times10(n2) + {3'b000, n3};
            end else begin
              keep = is_dig;
            end
          end
        end
      end
      vtlcd_pkg::SeqPos7: begin
        if (f2 && f3 && s4 == vtlcd_pkg::ChSemi && f5 && f6 &&
            char_i == vtlcd_pkg::ChUpperH) begin
          go  = 1'b1;
          col = times10(n5) + {3'b000, n6};
          row = times10(n2) + {3'b000, n3};
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    if (go) begin
      res_o.emit     = 1'b1;
      res_o.bus_byte = vtlcd_pkg::CmdDdram | {1'b0, addr};
    end

    st_o.pos = keep ? 3'(st_i.pos + 3'd1) : vtlcd_pkg::SeqIdle;
  end

  // Only the low two bits of the row number are used; rows past the last one saturate.
  always_comb begin
    if ({1'b0, row[1:0]} < 3'(ROW_COUNT)) begin
      row_sat = row[1:0];
    end else begin
      row_sat = 2'(ROW_COUNT - 1);
    end
  end

  assign addr = 7'(row_base_i[row_sat[RowIdxW-1:0]] + col);

endmodule

FILE: rtl/vt100_escape_to_lcd_command.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Beat
// in        sink       in_valid_i/in_ready_o, char_in_i     one terminal character
// out       source     out_valid_o/out_ready_i,             one controller write
//                      reg_select_o, bus_byte_o
// cfg       sink       cfg_valid_i/cfg_ready_o,             one row base register
//                      cfg_index_i, cfg_data_i
//
// A character beat is captured in an input register and decoded from there; a write
// it produces is registered in the output register and is offered on out from there.
// One character per cycle is sustained while out_ready_i is high. A held output beat
// stalls the decode stage, and in_ready_o then drops once the input register is full.
// Reset clears the parser to "no sequence" and loads the default row bases.
// Configuration writes are always accepted.
module vt100_escape_to_lcd_command #(
  parameter int unsigned ROW_COUNT = vtlcd_pkg::RowCountDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        char_in_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              reg_select_o,
  output logic [7:0]                        bus_byte_o,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vtlcd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vtlcd_pkg::AddrW-1:0]       cfg_data_i
);

  // Row base registers. Rows at or above ROW_COUNT are never addressed,
  // so only ROW_COUNT of them are kept and writes to the others are dropped.
  vtlcd_pkg::addr_t row_base_q [ROW_COUNT];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        row_base_q[i] <= vtlcd_pkg::RowBaseReset[i];
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        if (32'(cfg_index_i) == 32'(i)) begin
          row_base_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q, char_d;
  logic       advance;

  // The decode stage moves on whenever the output register is free or being drained.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    char_d     = char_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        char_d = char_in_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  // Parser state: position and digit flags are control, stored characters are payload.
  logic [vtlcd_pkg::PosW-1:0]                pos_q;
  logic [vtlcd_pkg::SeqChars-1:0]            dig_q;
  logic [vtlcd_pkg::SeqChars-1:0][7:0]       chr_q;
  vtlcd_pkg::parse_state_t                   st_cur;
  vtlcd_pkg::parse_state_t                   st_d;
  vtlcd_pkg::parse_result_t                  res;
  logic                                      step;

  assign st_cur = '{pos: pos_q, dig: dig_q, chr: chr_q};
  assign step   = in_valid_q && advance;

  vtlcd_step #(
    .ROW_COUNT (ROW_COUNT)
  ) u_step (
    .char_i     (char_q),
    .st_i       (st_cur),
    .row_base_i (row_base_q),
    .st_o       (st_d),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= vtlcd_pkg::SeqIdle;
      dig_q <= '0;
    end else if (step) begin
      pos_q <= st_d.pos;
      dig_q <= st_d.dig;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      chr_q <= st_d.chr;
    end
  end

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic       reg_select_q, reg_select_d;
  logic [7:0] bus_byte_q, bus_byte_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    reg_select_d = reg_select_q;
    bus_byte_d   = bus_byte_q;
    if (advance) begin
      out_valid_d = step && res.emit;
      if (step && res.emit) begin
        reg_select_d = res.reg_select;
        bus_byte_d   = res.bus_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reg_select_q <= reg_select_d;
    bus_byte_q   <= bus_byte_d;
  end

  assign out_valid_o  = out_valid_q;
  assign reg_select_o = reg_select_q;
  assign bus_byte_o   = bus_byte_q;

endmodule
